// ===== rtl/dec2i64_pkg.sv =====
`timescale 1ns / 1ps

package dec2i64_pkg;

  // ASCII codes the parser recognizes
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned DigitW = 4;

  // Magnitude bounds: 2^63 is the largest magnitude kept, and above a tenth
  // of it another digit cannot fit.
  localparam logic [ValueW-1:0] MagLimit = 64'h8000_0000_0000_0000;
  localparam logic [ValueW-1:0] MagTenth = 64'd922337203685477580;

endpackage

// ===== rtl/decimal_ascii_to_int64_parser.sv =====
`timescale 1ns / 1ps

// Decimal ASCII string to signed 64-bit integer parser.
//
// Input stream (s_axis_*): one character per request, tlast on the final
// character of the string. Output stream (m_axis_*): one request per string,
// sent after its last character, carrying the ok flag on tuser and the value
// on tdata (zero when ok is low).
//
// Each character goes into an input register and is folded into the running
// state when it is processed, by a single shift-add multiply-by-ten of the
// magnitude (and, in parallel, of its negation). One character per cycle is
// taken as long as the output side keeps up; a string's last character is
// judged from the input register and its result is written into the output
// register, from where the receiver takes it.
//
// When the receiver stalls, a finished result waits in the output register
// while the input register still takes the next character; once it holds a
// last character that cannot move, tready drops until the result is taken.
// Reset empties both registers and returns the parser to the start of a
// string.
module decimal_ascii_to_int64_parser (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [dec2i64_pkg::CharW-1:0]          s_axis_tdata_i,  // [7:0] char_byte
  input  logic                                   s_axis_tlast_i,  // is_last
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic signed [dec2i64_pkg::ValueW-1:0]  m_axis_tdata_o,  // [63:0] parsed_value
  output logic                                   m_axis_tuser_o   // [0] ok
);

  import dec2i64_pkg::*;

  typedef enum logic [1:0] {
    PhStart,
    PhMinus,
    PhDigits,
    PhZero
  } phase_e;

  // Input register
  logic             in_vld_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  // Parser state
  phase_e            phase_q, phase_d;
  logic              minus_q, minus_d;
  logic              failed_q, failed_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [ValueW-1:0] neg_q, neg_d;

  // Output register
  logic              out_vld_q;
  logic              out_ok_q;
  logic [ValueW-1:0] out_val_q;

  // Per-character next values
  phase_e            phase_n;
  logic              minus_n;
  logic              failed_n;
  logic [ValueW-1:0] mag_n;
  logic [ValueW-1:0] neg_n;

  logic              is_digit;
  logic              is_nonzero;
  logic [DigitW-1:0] digit;
  logic [ValueW-1:0] digit_ext;
  logic [ValueW-1:0] mag_x10;
  logic [ValueW-1:0] neg_x10;
  logic              good;
  logic [ValueW-1:0] value;

  logic              out_free;
  logic              proc_go;
  logic              in_take;

  // Handshake: process the held character unless it ends a string and the
  // output register is still occupied.
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign proc_go         = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_vld_q || proc_go;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Classify the character; '0'..'9' carry their value in the low nibble
  assign is_digit   = (in_char_q >= CharZero) && (in_char_q <= CharNine);
  assign is_nonzero = (in_char_q >= CharOne) && (in_char_q <= CharNine);
  assign digit      = in_char_q[DigitW-1:0];
  assign digit_ext  = {{(ValueW-DigitW){1'b0}}, digit};

  // Multiply by ten as shift-add, kept both positive and negated
  assign mag_x10 = (mag_q << 3) + (mag_q << 1) + digit_ext;
  assign neg_x10 = (neg_q << 3) + (neg_q << 1) - digit_ext;

  // Fold one character into the state
  always_comb begin
    phase_n  = phase_q;
    minus_n  = minus_q;
    failed_n = failed_q;
    mag_n    = mag_q;
    neg_n    = neg_q;
    if (!failed_q) begin
      unique case (phase_q)
        PhStart: begin
          if (in_char_q == CharZero) begin
            phase_n = PhZero;
          end else if (in_char_q == CharMinus) begin
            minus_n = 1'b1;
            phase_n = PhMinus;
          end else if (is_nonzero) begin
            mag_n   = digit_ext;
            neg_n   = '0 - digit_ext;
            phase_n = PhDigits;
          end else begin
            failed_n = 1'b1;
          end
        end
        PhMinus: begin
          if (is_nonzero) begin
            mag_n   = digit_ext;
            neg_n   = '0 - digit_ext;
            phase_n = PhDigits;
          end else begin
            failed_n = 1'b1;
          end
        end
        PhDigits: begin
          if (!is_digit || (mag_q > MagTenth)) begin
            failed_n = 1'b1;
          end else if (mag_x10 > MagLimit) begin
            failed_n = 1'b1;
          end else begin
            mag_n = mag_x10;
            neg_n = neg_x10;
          end
        end
        PhZero: begin
          failed_n = 1'b1;
        end
        default: begin
          failed_n = 1'b1;
        end
      endcase
    end
  end

  // Judge the string once its last character is folded in
  always_comb begin
    good  = 1'b0;
    value = '0;
    if (!failed_n) begin
      if (phase_n == PhZero) begin
        good = 1'b1;
      end else if (phase_n == PhDigits) begin
        if (minus_n) begin
          good  = 1'b1;
          value = neg_n;
        end else if (mag_n < MagLimit) begin
          good  = 1'b1;
          value = mag_n;
        end
      end
    end
  end

  // Advance the state, or return to the start after the last character
  always_comb begin
    phase_d  = phase_q;
    minus_d  = minus_q;
    failed_d = failed_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    if (proc_go) begin
      if (in_last_q) begin
        phase_d  = PhStart;
        minus_d  = 1'b0;
        failed_d = 1'b0;
        mag_d    = '0;
        neg_d    = '0;
      end else begin
        phase_d  = phase_n;
        minus_d  = minus_n;
        failed_d = failed_n;
        mag_d    = mag_n;
        neg_d    = neg_n;
      end
    end
  end

  // Hold state, input register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      in_char_q <= '0;
      in_last_q <= 1'b0;
      phase_q   <= PhStart;
      minus_q   <= 1'b0;
      failed_q  <= 1'b0;
      mag_q     <= '0;
      neg_q     <= '0;
      out_vld_q <= 1'b0;
      out_ok_q  <= 1'b0;
      out_val_q <= '0;
    end else begin
      if (in_take) begin
        in_vld_q  <= 1'b1;
        in_char_q <= s_axis_tdata_i;
        in_last_q <= s_axis_tlast_i;
      end else if (proc_go) begin
        in_vld_q <= 1'b0;
      end

      phase_q  <= phase_d;
      minus_q  <= minus_d;
      failed_q <= failed_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;

      if (proc_go && in_last_q) begin
        out_vld_q <= 1'b1;
        out_ok_q  <= good;
        out_val_q <= value;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = signed'(out_val_q);

  // A rejected string reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> out_val_q == '0)
    else $error("failed result carries a nonzero value");

  // A processed last character always yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && in_last_q |=> m_axis_tvalid_o)
    else $error("result missing after last character");

  // The parser is back at the start of a string after each result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && in_last_q |=> phase_q == PhStart && !failed_q && !minus_q && mag_q == '0)
    else $error("state not cleared after end of string");

  // The negated accumulator tracks the magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    neg_q == ('0 - mag_q))
    else $error("negated accumulator out of step with magnitude");

endmodule
